// File: rtl/core/sipq_pkg.sv
// ---------------------------------------------------------------------------
// sipq_pkg
// Shared types, constants and helpers for the sorted-insert priority queue.
// ---------------------------------------------------------------------------
package sipq_pkg;

    localparam int CAPACITY  = 128;
    localparam int PRIO_BITS = 4;
    localparam int TAG_W     = 32;
    localparam int PRIO_W    = 4;
    localparam int OCC_W     = 8;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]     tag;
        logic [PRIO_BITS-1:0] prio;
    } entry_t;

    // circular index: base + off, wrapped at CAPACITY
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/sipq_if.sv
// ---------------------------------------------------------------------------
// sipq_if
// Request and result channels of the priority queue (valid/ready).
// ---------------------------------------------------------------------------
interface sipq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [sipq_pkg::TAG_W-1:0]   packet_tag;
    logic [sipq_pkg::PRIO_W-1:0]  prio_level;

    modport source (output valid, output func, output packet_tag, output prio_level,
                    input ready);
    modport sink   (input valid, input func, input packet_tag, input prio_level,
                    output ready);
endinterface

interface sipq_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [sipq_pkg::TAG_W-1:0]   out_tag;
    logic [sipq_pkg::PRIO_W-1:0]  out_prio;
    logic [sipq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output out_tag, output out_prio,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_tag, input out_prio,
                    input occupancy, output ready);
endinterface

// File: rtl/core/sorted_insert_priority_queue_unit.sv
// Full insert, empty removal, insert into empty queue: result registered in the cycle after the request.
// Removal: the head entry goes through the registered memory read, then S_POP loads the result register.
// Insert: entries with larger priority are moved back one slot, one memory write per cycle,
// then the new entry is written and the result loaded; next request taken once the result register is free.
// Reset: count, head and control clear at once; the entry memory is not cleared.
// ---------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// Sorted priority queue in a circular single-port-write memory; inserts
// shift larger-priority entries back one per cycle, removals advance head.
// ---------------------------------------------------------------------------
module sorted_insert_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    sipq_req_if.sink    req,
    sipq_res_if.source  res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_PLACE = 4'b0100,
        S_POP   = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [sipq_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [sipq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [sipq_pkg::IDX_W-1:0]    pos_reg, pos_next;
    sipq_pkg::entry_t              new_reg, new_next;

    logic                          res_valid_reg, res_valid_next;
    sipq_pkg::status_t             res_status_reg;
    logic [sipq_pkg::TAG_W-1:0]    res_tag_reg;
    logic [sipq_pkg::PRIO_W-1:0]   res_prio_reg;
    logic [sipq_pkg::OCC_W-1:0]    res_occ_reg;

    logic                          res_load;
    sipq_pkg::status_t             res_status;
    logic [sipq_pkg::TAG_W-1:0]    res_tag;
    logic [sipq_pkg::PRIO_W-1:0]   res_prio;
    logic [sipq_pkg::CNT_W-1:0]    res_count;

    sipq_pkg::entry_t              mem [sipq_pkg::CAPACITY];
    sipq_pkg::entry_t              rd_data_reg;
    logic [sipq_pkg::IDX_W-1:0]    rd_addr;
    logic                          wr_en;
    logic [sipq_pkg::IDX_W-1:0]    wr_addr;
    sipq_pkg::entry_t              wr_data;

    logic                          accept;
    sipq_pkg::entry_t              req_entry;

    assign req.ready = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;
    assign req_entry = '{tag: req.packet_tag, prio: sipq_pkg::PRIO_BITS'(req.prio_level)};

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        new_next   = new_reg;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = sipq_pkg::wrap_idx(head_reg, pos_reg);
        wr_data    = new_reg;
        res_load   = 1'b0;
        res_status = sipq_pkg::ST_INSERTED;
        res_tag    = '0;
        res_prio   = '0;
        res_count  = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == sipq_pkg::FUNC_INSERT)
                    begin
                        new_next = req_entry;
                        if (count_reg == sipq_pkg::CNT_W'(sipq_pkg::CAPACITY))
                        begin
                            res_load   = 1'b1;
                            res_status = sipq_pkg::ST_DROPPED;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_reg;
                            wr_data    = req_entry;
                            count_next = sipq_pkg::CNT_W'(1);
                            res_load   = 1'b1;
                            res_count  = sipq_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            rd_addr    = sipq_pkg::wrap_idx(head_reg,
                                             sipq_pkg::IDX_W'(count_reg - sipq_pkg::CNT_W'(1)));
                            pos_next   = sipq_pkg::IDX_W'(count_reg);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_load   = 1'b1;
                            res_status = sipq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (rd_data_reg.prio > new_reg.prio)
                begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - sipq_pkg::IDX_W'(1);
                    if (pos_reg == sipq_pkg::IDX_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_addr = sipq_pkg::wrap_idx(head_reg, pos_reg - sipq_pkg::IDX_W'(2));
                    end
                end
                else
                begin
                    count_next = count_reg + sipq_pkg::CNT_W'(1);
                    res_load   = 1'b1;
                    res_count  = count_reg + sipq_pkg::CNT_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + sipq_pkg::CNT_W'(1);
                res_load   = 1'b1;
                res_count  = count_reg + sipq_pkg::CNT_W'(1);
                state_next = S_IDLE;
            end
            S_POP:
            begin
                head_next  = sipq_pkg::wrap_idx(head_reg, sipq_pkg::IDX_W'(1));
                count_next = count_reg - sipq_pkg::CNT_W'(1);
                res_load   = 1'b1;
                res_status = sipq_pkg::ST_REMOVED;
                res_tag    = rd_data_reg.tag;
                res_prio   = sipq_pkg::PRIO_W'(rd_data_reg.prio);
                res_count  = count_reg - sipq_pkg::CNT_W'(1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        if (res_load)
        begin
            res_status_reg <= res_status;
            res_tag_reg    <= res_tag;
            res_prio_reg   <= res_prio;
            res_occ_reg    <= sipq_pkg::OCC_W'(res_count);
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign res.valid     = res_valid_reg;
    assign res.status    = res_status_reg;
    assign res.out_tag   = res_tag_reg;
    assign res.out_prio  = res_prio_reg;
    assign res.occupancy = res_occ_reg;

endmodule
